[sv/hdp_pkg.sv]
package hdp_pkg;

   // Width of the byte position counter and of the segment start pointer.
   localparam int unsigned POS_BITS = 24;

   typedef logic [POS_BITS-1:0] pos_type;

   localparam pos_type POS_MAX        = {POS_BITS{1'b1}};
   localparam pos_type SEG_START_INIT = pos_type'(2);

   // Image formats as reported on the result channel.
   typedef enum logic [2:0] {
      FMT_UNKNOWN = 3'd0,
      FMT_JPEG    = 3'd1,
      FMT_PNG     = 3'd2,
      FMT_GIF     = 3'd3,
      FMT_BMP     = 3'd4
   } format_type;

   // Magic and marker bytes.
   localparam logic [7:0] JPG_MARK = 8'hFF;
   localparam logic [7:0] JPG_SOI  = 8'hD8;
   localparam logic [7:0] JPG_SOF0 = 8'hC0;
   localparam logic [7:0] JPG_SOF2 = 8'hC2;
   localparam logic [7:0] PNG_B0   = 8'h89;
   localparam logic [7:0] PNG_B1   = 8'h50;
   localparam logic [7:0] PNG_B2   = 8'h4E;
   localparam logic [7:0] PNG_B3   = 8'h47;
   localparam logic [7:0] GIF_B0   = 8'h47;
   localparam logic [7:0] GIF_B1   = 8'h49;
   localparam logic [7:0] GIF_B2   = 8'h46;
   localparam logic [7:0] GIF_B3   = 8'h38;
   localparam logic [7:0] BMP_B0   = 8'h42;
   localparam logic [7:0] BMP_B1   = 8'h4D;

   // Byte offsets inside a JPEG segment.
   localparam logic [3:0] SEG_OFF_MARK  = 4'd0;
   localparam logic [3:0] SEG_OFF_CODE  = 4'd1;
   localparam logic [3:0] SEG_OFF_LEN_H = 4'd2;
   localparam logic [3:0] SEG_OFF_LEN_L = 4'd3;
   localparam logic [3:0] SEG_OFF_HGT_H = 4'd5;
   localparam logic [3:0] SEG_OFF_HGT_L = 4'd6;
   localparam logic [3:0] SEG_OFF_WID_H = 4'd7;
   localparam logic [3:0] SEG_OFF_WID_L = 4'd8;
   localparam logic [3:0] SEG_OFF_DONE  = 4'd9;
   localparam pos_type    SEG_OFF_SPAN  = pos_type'(10);

   // Byte positions in the file.
   localparam pos_type POS_MAGIC_END = pos_type'(4);
   localparam pos_type POS_JPG_WALK  = pos_type'(2);
   localparam pos_type POS_CLASSIFY  = pos_type'(7);
   localparam pos_type POS_PNG_FIRST = pos_type'(16);
   localparam pos_type POS_PNG_WLAST = pos_type'(19);
   localparam pos_type POS_PNG_LAST  = pos_type'(23);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      format_type  format;
      logic        found;
      logic [31:0] width;
      logic [31:0] height;
   } rsp_item_type;

   function automatic format_type classify(input logic [31:0] m);
      format_type f;
      f = FMT_UNKNOWN;
      if (m[31:24] == JPG_MARK && m[23:16] == JPG_SOI && m[15:8] == JPG_MARK) begin
         f = FMT_JPEG;
      end else if (m[31:24] == PNG_B0 && m[23:16] == PNG_B1 &&
                   m[15:8] == PNG_B2 && m[7:0] == PNG_B3) begin
         f = FMT_PNG;
      end else if (m[31:24] == GIF_B0 && m[23:16] == GIF_B1 &&
                   m[15:8] == GIF_B2 && m[7:0] == GIF_B3) begin
         f = FMT_GIF;
      end else if (m[31:24] == BMP_B0 && m[23:16] == BMP_B1) begin
         f = FMT_BMP;
      end
      return f;
   endfunction

endpackage

[sv/image_header_dimension_parser.sv]
// Channel   Ports                                            Moves
// req       req_valid/req_ready, req_data_byte,              one file byte per transfer
//           req_first_byte, req_last_byte
// rsp       rsp_valid/rsp_ready, rsp_format, rsp_found,      at most one result per image
//           rsp_width, rsp_height
//
// One byte per cycle while the result slot is free: a byte waits in the input register;
// the parse logic updates the header state and, when settled, loads the result register.
// A byte's result reaches rsp through the input register and then the result register.
// Synchronous reset empties both registers and clears the parse state.
// A result still waiting in the output register stalls the parse only if rsp_ready is low;
// the input register then holds its byte and req_ready drops.
module image_header_dimension_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_format,
   output logic        rsp_found,
   output logic [31:0] rsp_width,
   output logic [31:0] rsp_height
);
   import hdp_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         out_free;
   logic         go;
   logic         emit;
   rsp_item_type result;
   rsp_item_type rsp_item;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.first_byte = req_first_byte;
   assign req_item.last_byte  = req_last_byte;

   // Advance the held byte through the parse whenever the result slot can take it.
   assign go = item_valid && out_free;

   hdp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (go),
      .item_valid (item_valid),
      .item       (item)
   );

   hdp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   hdp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (go && emit),
      .load_item (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_format = rsp_item.format;
   assign rsp_found  = rsp_item.found;
   assign rsp_width  = rsp_item.width;
   assign rsp_height = rsp_item.height;

endmodule

[sv/hdp_in_stage.sv]
module hdp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hdp_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output hdp_pkg::req_item_type item
);
   import hdp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // Take a new byte when the stage is empty or its byte moves on this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/hdp_parse_core.sv]
module hdp_parse_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  hdp_pkg::req_item_type item,
   output logic                  emit,
   output hdp_pkg::rsp_item_type result
);
   import hdp_pkg::*;

   pos_type     idx_ff, idx_in;
   logic [31:0] magic_ff, magic_in;
   format_type  fmt_ff, fmt_in;
   pos_type     seg_ff, seg_in;
   logic        sof_ff, sof_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] wid_ff, wid_in;
   logic [31:0] hgt_ff, hgt_in;
   logic        given_ff, given_in;
   logic        wfail_ff, wfail_in;

   logic [7:0]        b;
   pos_type           i;
   pos_type           off;
   logic [POS_BITS:0] seg_next;
   logic              found;
   logic              fail;

   assign b = item.data_byte;

   always_comb begin
      // Start from the held state, or the cleared state on a first byte.
      if (item.first_byte) begin
         idx_in   = '0;
         magic_in = '0;
         fmt_in   = FMT_UNKNOWN;
         seg_in   = SEG_START_INIT;
         sof_in   = 1'b0;
         len_in   = '0;
         wid_in   = '0;
         hgt_in   = '0;
         given_in = 1'b0;
         wfail_in = 1'b0;
      end else begin
         idx_in   = idx_ff;
         magic_in = magic_ff;
         fmt_in   = fmt_ff;
         seg_in   = seg_ff;
         sof_in   = sof_ff;
         len_in   = len_ff;
         wid_in   = wid_ff;
         hgt_in   = hgt_ff;
         given_in = given_ff;
         wfail_in = wfail_ff;
      end
      i        = idx_in;
      off      = i - seg_in;
      seg_next = '0;
      found    = 1'b0;
      fail     = 1'b0;

      if (!given_in) begin
         if (i == POS_MAX) begin
            fail = 1'b1;
         end else begin
            if (i < POS_MAGIC_END) begin
               case (i[1:0])
                  2'd0:    magic_in[31:24] = magic_in[31:24] | b;
                  2'd1:    magic_in[23:16] = magic_in[23:16] | b;
                  2'd2:    magic_in[15:8]  = magic_in[15:8] | b;
                  default: magic_in[7:0]   = magic_in[7:0] | b;
               endcase
            end
            if (i == POS_CLASSIFY) begin
               fmt_in = classify(magic_in);
            end

            // Walk JPEG segments by their length fields.
            if (i >= POS_JPG_WALK && magic_in[31:8] == {JPG_MARK, JPG_SOI, JPG_MARK} &&
                !wfail_in && i >= seg_in && off < SEG_OFF_SPAN) begin
               case (off[3:0])
                  SEG_OFF_MARK: begin
                     if (b != JPG_MARK) begin
                        wfail_in = 1'b1;
                     end
                  end
                  SEG_OFF_CODE:  sof_in = (b == JPG_SOF0) || (b == JPG_SOF2);
                  SEG_OFF_LEN_H: len_in = {8'd0, b};
                  SEG_OFF_LEN_L: begin
                     len_in = {len_in[7:0], b};
                     if (!sof_in) begin
                        if (len_in < 16'd2) begin
                           wfail_in = 1'b1;
                        end else begin
                           seg_next = {1'b0, seg_in} + (POS_BITS+1)'(2) +
                                      (POS_BITS+1)'(len_in);
                           seg_in = (seg_next > {1'b0, POS_MAX}) ? POS_MAX :
                                    seg_next[POS_BITS-1:0];
                        end
                     end
                  end
                  SEG_OFF_HGT_H: hgt_in = {24'd0, b};
                  SEG_OFF_HGT_L: hgt_in = {16'd0, hgt_in[7:0], b};
                  SEG_OFF_WID_H: wid_in = {24'd0, b};
                  SEG_OFF_WID_L: wid_in = {16'd0, wid_in[7:0], b};
                  SEG_OFF_DONE:  found = 1'b1;
                  default: ;
               endcase
            end

            if (fmt_in == FMT_PNG && i >= POS_PNG_FIRST && i <= POS_PNG_LAST) begin
               if (i <= POS_PNG_WLAST) begin
                  wid_in = {wid_in[23:0], b};
               end else begin
                  hgt_in = {hgt_in[23:0], b};
               end
               if (i == POS_PNG_LAST) begin
                  found = 1'b1;
               end
            end

            if (!found) begin
               if (i >= POS_CLASSIFY && fmt_in != FMT_JPEG && fmt_in != FMT_PNG) begin
                  fail = 1'b1;
               end
               if (i >= POS_CLASSIFY && fmt_in == FMT_JPEG && wfail_in) begin
                  fail = 1'b1;
               end
               if (item.last_byte) begin
                  fail = 1'b1;
               end
            end
         end
         idx_in = (i == POS_MAX) ? i : i + pos_type'(1);
         if (found || fail) begin
            given_in = 1'b1;
         end
      end

      // Only a byte that is still parsed can raise found or fail.
      emit          = found || fail;
      result.format = fmt_in;
      result.found  = found;
      result.width  = found ? wid_in : '0;
      result.height = found ? hgt_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         magic_ff <= '0;
         fmt_ff   <= FMT_UNKNOWN;
         seg_ff   <= SEG_START_INIT;
         sof_ff   <= 1'b0;
         len_ff   <= '0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         given_ff <= 1'b0;
         wfail_ff <= 1'b0;
      end else if (go) begin
         idx_ff   <= idx_in;
         magic_ff <= magic_in;
         fmt_ff   <= fmt_in;
         seg_ff   <= seg_in;
         sof_ff   <= sof_in;
         len_ff   <= len_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         given_ff <= given_in;
         wfail_ff <= wfail_in;
      end
   end

endmodule

[sv/hdp_out_stage.sv]
module hdp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hdp_pkg::rsp_item_type load_item,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hdp_pkg::rsp_item_type rsp_item
);
   import hdp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // The slot is free when empty or when its result leaves this cycle.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[tb/sv/header_dims_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the header parser. Each accepted byte runs
// through a shadow parse; the results it predicts queue up in order and
// are compared with what comes out of the rsp channel.
module header_dims_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_format,
   input  logic        rsp_found,
   input  logic [31:0] rsp_width,
   input  logic [31:0] rsp_height,
   output int          mismatches,
   output int          pending_results,
   output int          results_seen,
   output int          dims_seen
);
   import hdp_pkg::*;

   // Shadow parse state.
   pos_type     next_pos;
   logic [31:0] magic;
   format_type  fmt;
   pos_type     seg_start;
   logic        seg_sof;
   logic [15:0] seg_len;
   logic [31:0] wid_acc;
   logic [31:0] hgt_acc;
   logic        reported;
   logic        walk_dead;

   rsp_item_type expected_dims[$];
   rsp_item_type want;

   initial pending_results = 0;

   function automatic format_type format_of(input logic [31:0] m);
      if (m[31:8] == {JPG_MARK, JPG_SOI, JPG_MARK})
         return FMT_JPEG;
      if (m == {PNG_B0, PNG_B1, PNG_B2, PNG_B3})
         return FMT_PNG;
      if (m == {GIF_B0, GIF_B1, GIF_B2, GIF_B3})
         return FMT_GIF;
      if (m[31:16] == {BMP_B0, BMP_B1})
         return FMT_BMP;
      return FMT_UNKNOWN;
   endfunction

   task automatic restart_parse();
      next_pos  = '0;
      magic     = '0;
      fmt       = FMT_UNKNOWN;
      seg_start = SEG_START_INIT;
      seg_sof   = 1'b0;
      seg_len   = '0;
      wid_acc   = '0;
      hgt_acc   = '0;
      reported  = 1'b0;
      walk_dead = 1'b0;
   endtask

   task automatic take_header_byte(input logic [7:0] b, input logic first, input logic last);
      pos_type           pos;
      pos_type           off;
      logic [POS_BITS:0] seg_next;
      logic              hit;
      logic              bad;
      rsp_item_type      res;
      hit = 1'b0;
      bad = 1'b0;
      if (first)
         restart_parse();
      if (reported)
         return;
      pos = next_pos;
      if (pos == POS_MAX) begin
         bad = 1'b1;
      end else begin
         case (pos)
            0: magic[31:24] = b;
            1: magic[23:16] = b;
            2: magic[15:8]  = b;
            3: magic[7:0]   = b;
            default: ;
         endcase
         if (pos == POS_CLASSIFY)
            fmt = format_of(magic);

         // JPEG segment walk, keyed on the offset inside the current segment
         if (pos >= POS_JPG_WALK && magic[31:8] == {JPG_MARK, JPG_SOI, JPG_MARK} &&
             !walk_dead && pos >= seg_start) begin
            off = pos - seg_start;
            case (off)
               SEG_OFF_MARK: if (b != JPG_MARK) walk_dead = 1'b1;
               SEG_OFF_CODE: seg_sof = (b == JPG_SOF0 || b == JPG_SOF2);
               SEG_OFF_LEN_H: seg_len = {8'h00, b};
               SEG_OFF_LEN_L: begin
                  seg_len = {seg_len[7:0], b};
                  if (!seg_sof) begin
                     if (seg_len < 16'd2) begin
                        walk_dead = 1'b1;
                     end else begin
                        seg_next = seg_start + 2 + seg_len;
                        if (seg_next > POS_MAX)
                           seg_start = POS_MAX;
                        else
                           seg_start = seg_next[POS_BITS-1:0];
                     end
                  end
               end
               SEG_OFF_HGT_H: hgt_acc = {24'd0, b};
               SEG_OFF_HGT_L: hgt_acc = {16'd0, hgt_acc[7:0], b};
               SEG_OFF_WID_H: wid_acc = {24'd0, b};
               SEG_OFF_WID_L: wid_acc = {16'd0, wid_acc[7:0], b};
               SEG_OFF_DONE:  hit = 1'b1;
               default: ;
            endcase
         end

         // PNG: big-endian width then height straight out of the IHDR chunk
         if (fmt == FMT_PNG && pos >= POS_PNG_FIRST && pos <= POS_PNG_LAST) begin
            if (pos <= POS_PNG_WLAST)
               wid_acc = {wid_acc[23:0], b};
            else
               hgt_acc = {hgt_acc[23:0], b};
            if (pos == POS_PNG_LAST)
               hit = 1'b1;
         end

         if (!hit) begin
            if (pos >= POS_CLASSIFY && fmt != FMT_JPEG && fmt != FMT_PNG)
               bad = 1'b1;
            if (pos >= POS_CLASSIFY && fmt == FMT_JPEG && walk_dead)
               bad = 1'b1;
            if (last)
               bad = 1'b1;
         end
      end

      if (pos != POS_MAX)
         next_pos = pos + 1'b1;

      if (hit || bad) begin
         reported   = 1'b1;
         res.format = fmt;
         res.found  = hit;
         res.width  = hit ? wid_acc : '0;
         res.height = hit ? hgt_acc : '0;
         expected_dims.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_parse();
         expected_dims.delete();
      end else begin
         if (req_valid && req_ready)
            take_header_byte(req_data_byte, req_first_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_dims.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result fmt=%0d found=%0d w=%0h h=%0h",
                           $time, rsp_format, rsp_found, rsp_width, rsp_height);
               mismatches++;
            end else begin
               want = expected_dims.pop_front();
               results_seen++;
               if (want.found)
                  dims_seen++;
               if (rsp_format !== want.format || rsp_found !== want.found ||
                   rsp_width !== want.width || rsp_height !== want.height) begin
                  if (mismatches < 10)
                     $display("%0t: result fmt=%0d found=%0d w=%0h h=%0h, wanted %0d %0d %0h %0h",
                              $time, rsp_format, rsp_found, rsp_width, rsp_height,
                              want.format, want.found, want.width, want.height);
                  mismatches++;
               end
            end
         end
      end
      pending_results <= expected_dims.size();
   end

endmodule

[tb/sv/image_header_dimension_parser_tb.sv]
`timescale 1ns / 1ps

// Top of the parser bench: builds image files byte by byte, streams them
// into the block with random gaps, throttles the result side at random,
// and gives the verdict from the checker's counts.
module image_header_dimension_parser_tb;
   import hdp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_format;
   logic        rsp_found;
   logic [31:0] rsp_width;
   logic [31:0] rsp_height;

   // High while both sides run without any idling.
   logic        quiet = 1'b0;

   int mismatches;
   int pending_results;
   int results_seen;
   int dims_seen;

   // File under construction, and running totals for the summary.
   logic [7:0] img[$];
   int         bytes_sent;
   int         trail_sent;
   int         images;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   image_header_dimension_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_format     (rsp_format),
      .rsp_found      (rsp_found),
      .rsp_width      (rsp_width),
      .rsp_height     (rsp_height)
   );

   header_dims_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_format      (rsp_format),
      .rsp_found       (rsp_found),
      .rsp_width       (rsp_width),
      .rsp_height      (rsp_height),
      .mismatches      (mismatches),
      .pending_results (pending_results),
      .results_seen    (results_seen),
      .dims_seen       (dims_seen)
   );

   // Stall the result side with a probability of 22 in a hundred, never while quiet.
   always @(posedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 22);

   // Give up well past the slowest legal run.
   initial begin
      #30_000_000;
      $display("Run timed out");
      $display("TB_ERROR");
      $finish;
   end

   task automatic push_bytes(input int count);
      repeat (count) img.push_back(8'($urandom));
   endtask

   task automatic push_word(input logic [31:0] w);
      img.push_back(w[31:24]);
      img.push_back(w[23:16]);
      img.push_back(w[15:8]);
      img.push_back(w[7:0]);
   endtask

   // Skipped JPEG segment: marker, code, length, then length-2 bytes of body.
   task automatic push_segment(input logic [7:0] code, input logic [15:0] len);
      push_word({JPG_MARK, code, len});
      if (len > 16'd2)
         push_bytes(len - 2);
   endtask

   // Frame header up to its component count, the byte that completes the parse.
   task automatic push_sof(input logic [7:0] code, input logic [15:0] len,
                           input logic [15:0] hgt, input logic [15:0] wid);
      push_word({JPG_MARK, code, len});
      img.push_back(8'h08);
      push_word({hgt, wid});
      img.push_back(8'h03);
   endtask

   // Signature, IHDR length and tag, then width and height.
   task automatic push_png(input logic [31:0] wid, input logic [31:0] hgt);
      push_word({PNG_B0, PNG_B1, PNG_B2, PNG_B3});
      push_word(32'h0D0A_1A0A);
      push_word(32'h0000_000D);
      push_word(32'h4948_4452);
      push_word(wid);
      push_word(hgt);
   endtask

   task automatic start_jpeg();
      img.push_back(JPG_MARK);
      img.push_back(JPG_SOI);
   endtask

   task automatic cut_to(input int len);
      while (img.size() > len)
         void'(img.pop_back());
   endtask

   // Stream the file, then trail bytes of noise with random last flags.
   // Hold each byte until its transfer; drop valid only for a random gap.
   task automatic send_image(input bit mark_first, input bit mark_last, input int trail);
      int n;
      n = img.size();
      for (int k = 0; k < n + trail; k++) begin
         while (!quiet && $urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid      <= 1'b1;
         req_data_byte  <= (k < n) ? img[k] : 8'($urandom);
         req_first_byte <= mark_first && (k == 0);
         req_last_byte  <= (k < n) ? (mark_last && k == n - 1) : 1'($urandom);
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
      end
      bytes_sent += n;
      trail_sent += trail;
      images++;
      img.delete();
   endtask

   initial begin
      int          base_bytes;
      int          base_images;
      int          pick;
      int          trail;
      int          wait_cycles;
      bit          mark_last;
      logic [15:0] len;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed files ----
      // PNG straight after reset without the first flag, all-ones dimensions
      push_png(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_image(1'b0, 1'b1, 0);
      // zero dimensions, last flag landing on the final height byte
      push_png(32'h0, 32'h0);
      send_image(1'b1, 1'b1, 0);
      // PNG cut short inside the height field
      push_png(32'h0000_0280, 32'h0000_01E0);
      cut_to(21);
      send_image(1'b1, 1'b1, 0);
      // single-byte file: first and last on the same transfer
      img.push_back(JPG_MARK);
      send_image(1'b1, 1'b1, 0);
      // seven bytes of JPEG: ends before classification, format stays unknown
      start_jpeg();
      push_segment(8'hE0, 16'h0010);
      cut_to(7);
      send_image(1'b1, 1'b1, 0);
      // eight bytes of JPEG: classified, walk still inside the first segment
      start_jpeg();
      push_segment(8'hE0, 16'h0010);
      cut_to(8);
      send_image(1'b1, 1'b1, 0);
      // baseline frame header right at offset 2, largest dimensions, trailing junk
      start_jpeg();
      push_sof(JPG_SOF0, 16'h0011, 16'hFFFF, 16'hFFFF);
      send_image(1'b1, 1'b1, 3);
      // progressive frame behind an APP0 segment, zero dimensions, no last flag
      start_jpeg();
      push_segment(8'hE0, 16'h0010);
      push_sof(JPG_SOF2, 16'h0011, 16'h0000, 16'h0000);
      send_image(1'b1, 1'b0, 0);
      // shortest legal skip, then an SOF1 that must be skipped, then SOF0
      start_jpeg();
      push_segment(8'hE1, 16'h0002);
      push_segment(8'hC1, 16'h000B);
      push_sof(JPG_SOF0, 16'h0011, 16'h1234, 16'h5678);
      send_image(1'b1, 1'b1, 0);
      // frame header with a zero length field still yields its dimensions
      start_jpeg();
      push_sof(JPG_SOF0, 16'h0000, 16'hA5A5, 16'h5A5A);
      send_image(1'b1, 1'b1, 0);
      // skip lengths of zero and one: walk fails, result waits for byte 7
      start_jpeg();
      push_segment(8'hDB, 16'h0000);
      push_bytes(6);
      send_image(1'b1, 1'b1, 0);
      start_jpeg();
      push_segment(8'hC4, 16'h0001);
      push_bytes(6);
      send_image(1'b1, 1'b1, 0);
      // missing marker before classification
      start_jpeg();
      push_segment(8'hE0, 16'h0002);
      img.push_back(8'h12);
      push_bytes(6);
      send_image(1'b1, 1'b1, 0);
      // missing marker after classification
      start_jpeg();
      push_segment(8'hE0, 16'h0006);
      img.push_back(8'h00);
      push_bytes(4);
      send_image(1'b1, 1'b1, 0);
      // frame header cut one byte short of the component count
      start_jpeg();
      push_segment(8'hFE, 16'h0005);
      push_sof(JPG_SOF2, 16'h0011, 16'h0100, 16'h0200);
      cut_to(img.size() - 1);
      send_image(1'b1, 1'b1, 0);
      // abandoned file with no result; the next first flag restarts the parse
      start_jpeg();
      push_word({JPG_MARK, 8'hE0, 8'h00, 8'h10});
      send_image(1'b1, 1'b0, 0);
      // GIF, BMP, and a near-GIF that is unknown
      push_word({GIF_B0, GIF_B1, GIF_B2, GIF_B3});
      push_bytes(6);
      send_image(1'b1, 1'b1, 0);
      push_word({BMP_B0, BMP_B1, 16'h1234});
      push_bytes(4);
      send_image(1'b1, 1'b1, 2);
      push_word({GIF_B0, GIF_B1, GIF_B2, 8'h39});
      push_bytes(4);
      send_image(1'b1, 1'b1, 0);
      // long skip segment before the frame header
      start_jpeg();
      push_segment(8'hED, 16'h0040);
      push_sof(JPG_SOF2, 16'h0011, 16'h0438, 16'h0780);
      send_image(1'b1, 1'b1, 0);

      // ---- random files ----
      base_bytes  = bytes_sent;
      base_images = images;
      while (bytes_sent - base_bytes < 120 || images - base_images < 6) begin
         // hold a run of files with no idling on either side
         quiet     <= (images - base_images >= 2) && (images - base_images < 5);
         pick      = $urandom_range(99);
         trail     = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0;
         mark_last = ($urandom_range(6) != 0);
         if (pick < 45 || pick >= 80) begin
            start_jpeg();
            repeat ($urandom_range(0, 3)) begin
               len = ($urandom_range(19) == 0) ? 16'($urandom_range(31, 60))
                                               : 16'($urandom_range(2, 30));
               push_segment(8'($urandom_range(8'hC3, 8'hFE)), len);
            end
            push_sof($urandom_range(1) ? JPG_SOF2 : JPG_SOF0, 16'h0011,
                     16'($urandom), 16'($urandom));
            // broken variants: bad length, lost marker, or a corrupted byte
            if (pick >= 80) begin
               case ($urandom_range(2))
                  0: begin
                     img.delete();
                     start_jpeg();
                     push_segment(8'hE0, 16'($urandom_range(1)));
                     push_bytes($urandom_range(2, 12));
                  end
                  1: img[2 + 4 * $urandom_range(0, 1)] = 8'($urandom_range(8'hFE));
                  default: img[$urandom_range(img.size() - 1)] = 8'($urandom);
               endcase
            end
         end else if (pick < 65) begin
            push_png($urandom, $urandom);
         end else if (pick < 73) begin
            if ($urandom_range(1))
               push_word({GIF_B0, GIF_B1, GIF_B2, GIF_B3});
            else
               push_word({BMP_B0, BMP_B1, 16'($urandom)});
            push_bytes($urandom_range(4, 10));
         end else begin
            push_bytes($urandom_range(1, 12));
         end
         // truncate some files so the last flag ends them early
         if ($urandom_range(7) == 0 && img.size() > 1)
            cut_to($urandom_range(1, img.size() - 1));
         send_image(1'b1, mark_last, trail);
      end
      quiet     <= 1'b0;
      req_valid <= 1'b0;

      // Let the last transfers reach the checker, then drain the results.
      repeat (2) @(posedge clock);
      wait_cycles = 0;
      while (pending_results != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);

      if (pending_results != 0)
         $display("%0d predicted results never arrived", pending_results);
      $display("Streamed %0d images: %0d header bytes plus %0d trailing bytes",
               images, bytes_sent, trail_sent);
      $display("Checked %0d results, %0d carrying dimensions", results_seen, dims_seen);
      if (mismatches == 0 && pending_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[image_header_dimension_parser.f]
sv/hdp_pkg.sv
sv/hdp_in_stage.sv
sv/hdp_parse_core.sv
sv/hdp_out_stage.sv
sv/image_header_dimension_parser.sv
tb/sv/header_dims_checker.sv
tb/sv/image_header_dimension_parser_tb.sv
